>>> rtl/core/fpwc_pkg.sv
// Package for the page write combiner: shared widths, codes and the
// handoff structs between the fill side and the drain side.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fpwc_pkg;

  localparam int ADDR_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int LANES   = 8;
  localparam int WORD_W  = LANES * BYTE_W;
  localparam int INDEX_W = 2;

  // action codes
  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // page handed from the fill side to the drain side
  typedef struct packed {
    logic              emit;
    logic              bank;
    logic [ADDR_W-1:0] base;
  } emit_t;

  // bank released by the drain side after its last word left
  typedef struct packed {
    logic rel;
    logic bank;
  } rel_t;

endpackage

`default_nettype wire

>>> rtl/core/fpwc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while no read is issued. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module fpwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/fpwc_writer.sv
// Fill side: chunk address decode, base/fill/next-address state, byte-valid
// flags per bank and the byte write into the page RAM. Uses fpwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpwc_writer #(
  parameter int PAGE_BYTES = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            action_i,
  input  wire logic                            chunk_start_i,
  input  wire logic [fpwc_pkg::ADDR_W-1:0]     byte_addr_i,
  input  wire logic [fpwc_pkg::BYTE_W-1:0]     data_byte_i,
  input  wire logic                            busy_i,
  input  wire fpwc_pkg::rel_t                  rel_i,
  output fpwc_pkg::emit_t                      emit_o,
  output logic [fpwc_pkg::LANES-1:0]           wr_en_o,
  output logic [(((PAGE_BYTES/8) > 1) ? $clog2(PAGE_BYTES/8) : 1):0] wr_addr_o,
  output logic [fpwc_pkg::BYTE_W-1:0]          wr_data_o,
  output logic [1:0][PAGE_BYTES-1:0]           vld_o
);
  import fpwc_pkg::*;

  localparam int PAGE_WORDS = PAGE_BYTES / 8;
  localparam int WRD_W      = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;
  localparam int OFF_W      = $clog2(PAGE_BYTES);
  localparam int CNT_W      = $clog2(PAGE_BYTES + 1);

  logic [ADDR_W-1:0]          base_q, base_d;
  logic [ADDR_W-1:0]          next_q, next_d;
  logic [CNT_W-1:0]           fill_q, fill_d;
  logic                       drop_q, drop_d;
  logic                       bank_q, bank_d;
  logic [1:0][PAGE_BYTES-1:0] vld_q, vld_d;

  logic [ADDR_W-1:0] off_full;
  logic [ADDR_W-1:0] wr_byte_addr;
  logic [ADDR_W-1:0] new_base;
  logic [OFF_W-1:0]  wr_off;
  logic [CNT_W-1:0]  new_fill;
  logic              is_flush;
  logic              empty;
  logic              below;
  logic              do_wr;
  logic              do_drop;
  logic              beyond;
  logic              full;
  logic              flush_emit;
  logic              emit_need;
  logic              acc;
  logic              wr_bank;

  // decode of the offered beat against the current buffer
  always_comb begin
    off_full     = byte_addr_i - base_q;
    below        = byte_addr_i < base_q;
    is_flush     = action_i == ACT_FLUSH;
    empty        = fill_q == '0;
    do_wr        = 1'b0;
    do_drop      = 1'b0;
    beyond       = 1'b0;
    wr_off       = '0;
    wr_byte_addr = next_q;
    new_base     = base_q;
    if (!is_flush) begin
      if (chunk_start_i) begin
        wr_byte_addr = byte_addr_i;
        if (empty) begin
          do_wr    = 1'b1;
          new_base = byte_addr_i;
        end else if (below || (off_full < ADDR_W'(fill_q))) begin
          do_drop = 1'b1;
        end else if (off_full >= ADDR_W'(PAGE_BYTES)) begin
          beyond   = 1'b1;
          do_wr    = 1'b1;
          new_base = byte_addr_i;
        end else begin
          do_wr  = 1'b1;
          wr_off = OFF_W'(off_full);
        end
      end else if (!drop_q) begin
        do_wr  = 1'b1;
        wr_off = OFF_W'(fill_q);
        if (empty) begin
          new_base = next_q;
        end
      end
    end
    new_fill   = CNT_W'(wr_off) + CNT_W'(1);
    full       = do_wr && (new_fill == CNT_W'(PAGE_BYTES));
    flush_emit = is_flush && !empty;
    emit_need  = flush_emit || beyond || full;
  end

  // a page handoff waits while the other bank is still draining
  assign in_ready_o = !(busy_i && emit_need);
  assign acc        = in_valid_i && in_ready_o;
  assign wr_bank    = beyond ? ~bank_q : bank_q;

  // next state
  always_comb begin
    base_d = base_q;
    next_d = next_q;
    fill_d = fill_q;
    drop_d = drop_q;
    bank_d = bank_q;
    vld_d  = vld_q;
    if (rel_i.rel) begin
      vld_d[rel_i.bank] = '0;
    end
    if (acc) begin
      if (emit_need) begin
        bank_d = ~bank_q;
      end
      if (!is_flush && chunk_start_i) begin
        drop_d = do_drop;
      end
      if (do_wr) begin
        base_d                 = new_base;
        next_d                 = wr_byte_addr + ADDR_W'(1);
        fill_d                 = full ? '0 : new_fill;
        vld_d[wr_bank][wr_off] = 1'b1;
      end else if (flush_emit) begin
        fill_d = '0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      next_q <= '0;
      fill_q <= '0;
      drop_q <= 1'b0;
      bank_q <= 1'b0;
      vld_q  <= '0;
    end else begin
      base_q <= base_d;
      next_q <= next_d;
      fill_q <= fill_d;
      drop_q <= drop_d;
      bank_q <= bank_d;
      vld_q  <= vld_d;
    end
  end

  // page handoff, the emitted page always sits in the current bank
  assign emit_o.emit = acc && emit_need;
  assign emit_o.bank = bank_q;
  assign emit_o.base = base_q;

  // byte write into the lane RAMs
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      wr_en_o[l] = acc && do_wr && (wr_off[2:0] == 3'(l));
    end
  end

  assign wr_addr_o = {wr_bank, WRD_W'(wr_off >> 3)};
  assign wr_data_o = data_byte_i;
  assign vld_o     = vld_q;

endmodule

`default_nettype wire

>>> rtl/core/fpwc_drain.sv
// Drain side: reads a finished page bank word by word from the lane RAMs and
// presents the words on the output channel, masking bytes never written.
// Uses fpwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpwc_drain #(
  parameter int PAGE_BYTES = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire fpwc_pkg::emit_t                 emit_i,
  output logic                                 busy_o,
  output fpwc_pkg::rel_t                       rel_o,
  output logic                                 rd_en_o,
  output logic [(((PAGE_BYTES/8) > 1) ? $clog2(PAGE_BYTES/8) : 1):0] rd_addr_o,
  input  wire logic [fpwc_pkg::WORD_W-1:0]     rd_data_i,
  input  wire logic [1:0][PAGE_BYTES-1:0]      vld_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [fpwc_pkg::ADDR_W-1:0]          page_addr_o,
  output logic [fpwc_pkg::INDEX_W-1:0]         word_index_o,
  output logic [fpwc_pkg::WORD_W-1:0]          page_word_o,
  output logic                                 last_word_o
);
  import fpwc_pkg::*;

  localparam int PAGE_WORDS = PAGE_BYTES / 8;
  localparam int WRD_W      = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;
  localparam logic [WRD_W-1:0] LAST_WORD = WRD_W'(PAGE_WORDS - 1);

  logic              busy_q, busy_d;
  logic              dbank_q, dbank_d;
  logic [ADDR_W-1:0] dbase_q, dbase_d;
  logic [WRD_W-1:0]  rd_word_q, rd_word_d;
  logic              rd_done_q, rd_done_d;
  logic              out_valid_q, out_valid_d;
  logic [WRD_W-1:0]  out_word_q, out_word_d;

  logic out_fire;
  logic issue;
  logic release_bank;

  assign out_fire     = out_valid_q && out_ready_i;
  assign release_bank = out_fire && (out_word_q == LAST_WORD);
  // one word in flight at most: the RAM read register is the output stage
  assign issue        = busy_q && !rd_done_q && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    busy_d      = busy_q;
    dbank_d     = dbank_q;
    dbase_d     = dbase_q;
    rd_word_d   = rd_word_q;
    rd_done_d   = rd_done_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (emit_i.emit) begin
      busy_d    = 1'b1;
      dbank_d   = emit_i.bank;
      dbase_d   = emit_i.base;
      rd_word_d = '0;
      rd_done_d = 1'b0;
    end
    if (issue) begin
      out_valid_d = 1'b1;
      out_word_d  = rd_word_q;
      if (rd_word_q == LAST_WORD) begin
        rd_done_d = 1'b1;
      end else begin
        rd_word_d = rd_word_q + WRD_W'(1);
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (release_bank) begin
      busy_d = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      dbank_q     <= 1'b0;
      dbase_q     <= '0;
      rd_word_q   <= '0;
      rd_done_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      busy_q      <= busy_d;
      dbank_q     <= dbank_d;
      dbase_q     <= dbase_d;
      rd_word_q   <= rd_word_d;
      rd_done_q   <= rd_done_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

  assign rd_en_o   = issue;
  assign rd_addr_o = {dbank_q, rd_word_q};
  assign busy_o    = busy_q;
  assign rel_o.rel  = release_bank;
  assign rel_o.bank = dbank_q;

  // unwritten bytes read as zero
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      page_word_o[b*BYTE_W +: BYTE_W] = rd_data_i[b*BYTE_W +: BYTE_W]
        & {BYTE_W{vld_i[dbank_q][{out_word_q, 3'(b)}]}};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign page_addr_o  = dbase_q;
  assign word_index_o = INDEX_W'(out_word_q);
  assign last_word_o  = out_word_q == LAST_WORD;

endmodule

`default_nettype wire

>>> rtl/core/flash_page_write_combiner_top.sv
// Top level of the page write combiner: fill side, drain side and eight
// byte-lane RAMs holding two page banks. Uses fpwc_pkg, fpwc_ram,
// fpwc_writer and fpwc_drain.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one beat per cycle, unless
//   held off (below): a data byte (with the chunk address on a chunk's first
//   beat) or a flush. Output channel (out_valid_o / out_ready_i) gives each
//   written page as PAGE_BYTES/8 words of 64 bits, lowest address in the low
//   byte, with last_word_o on the final word.
//   Throughput: one input beat per cycle while in_ready_o is high. The page
//   is held in two banks, so bytes of the next page are taken while the
//   previous page drains. A beat that would hand over a page while the
//   other bank still drains is held off (in_ready_o low until that bank is
//   released); in_ready_o depends on the offered payload.
//   Output: the drain registers the page handoff, then reads the first word
//   into the RAM read register; further words follow one per cycle while
//   out_ready_i is high, set by the single RAM read port. The output goes
//   idle between two pages.
//   Receiver stall: the word on the output holds in the RAM read register;
//   input beats keep flowing into the other bank.
//   Reset: all control state cleared at once, byte-valid flags included; no
//   clearing pass, the block takes beats right after reset.
`timescale 1ns / 1ps
`default_nettype none

module flash_page_write_combiner_top #(
  parameter int PAGE_BYTES = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            action_i,
  input  wire logic                            chunk_start_i,
  input  wire logic [fpwc_pkg::ADDR_W-1:0]     byte_addr_i,
  input  wire logic [fpwc_pkg::BYTE_W-1:0]     data_byte_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [fpwc_pkg::ADDR_W-1:0]          page_addr_o,
  output logic [fpwc_pkg::INDEX_W-1:0]         word_index_o,
  output logic [fpwc_pkg::WORD_W-1:0]          page_word_o,
  output logic                                 last_word_o
);
  import fpwc_pkg::*;

  localparam int PAGE_WORDS = PAGE_BYTES / 8;
  localparam int WRD_W      = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;
  localparam int RAM_AW     = WRD_W + 1;
  localparam int RAM_DEPTH  = 2 ** RAM_AW;

  emit_t                      emit;
  rel_t                       rel;
  logic                       busy;
  logic [LANES-1:0]           wr_en;
  logic [RAM_AW-1:0]          wr_addr;
  logic [BYTE_W-1:0]          wr_data;
  logic                       rd_en;
  logic [RAM_AW-1:0]          rd_addr;
  logic [LANES-1:0][BYTE_W-1:0] lane_rd;
  logic [1:0][PAGE_BYTES-1:0] vld;

  // fill side
  fpwc_writer #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_writer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .chunk_start_i(chunk_start_i),
    .byte_addr_i  (byte_addr_i),
    .data_byte_i  (data_byte_i),
    .busy_i       (busy),
    .rel_i        (rel),
    .emit_o       (emit),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .vld_o        (vld)
  );

  // byte-lane page RAMs, address is {bank, word}
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    fpwc_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(RAM_DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr_en[g]),
      .waddr_i(wr_addr),
      .wdata_i(wr_data),
      .re_i   (rd_en),
      .raddr_i(rd_addr),
      .rdata_o(lane_rd[g])
    );
  end

  // drain side
  fpwc_drain #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .busy_o      (busy),
    .rel_o       (rel),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (lane_rd),
    .vld_i       (vld),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .page_addr_o (page_addr_o),
    .word_index_o(word_index_o),
    .page_word_o (page_word_o),
    .last_word_o (last_word_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/fpwc_checker.sv
// Port-level checker for the page write combiner output channel, bound to
// the top level. Uses only the top-level ports.
`timescale 1ns / 1ps
`default_nettype none

module fpwc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] page_addr_o,
  input wire logic [1:0]  word_index_o,
  input wire logic [63:0] page_word_o,
  input wire logic        last_word_o
);

  // output beat holds until taken
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before the beat was taken");

  // stalled beat keeps its payload
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(page_addr_o) && $stable(word_index_o)
      && $stable(page_word_o) && $stable(last_word_o))
    else $error("stalled output beat changed");

  // words of one page follow back to back with the same page address
  a_word_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_word_o |=> out_valid_o
      && (word_index_o == $past(word_index_o) + 2'd1)
      && (page_addr_o == $past(page_addr_o)))
    else $error("page word sequence broken");

  // a page starts at word zero
  a_page_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> word_index_o == 2'd0)
    else $error("page did not start at word zero");

  // drain releases the bank before the next page shows up
  a_page_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_word_o |=> !out_valid_o)
    else $error("next page followed its predecessor without a gap");

endmodule

bind flash_page_write_combiner_top fpwc_checker u_fpwc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .page_addr_o (page_addr_o),
  .word_index_o(word_index_o),
  .page_word_o (page_word_o),
  .last_word_o (last_word_o)
);

`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for flash_page_write_combiner_top: a directed table, then random chunks.
// Predicted page words are compared with the output beats; needs fpwc_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import fpwc_pkg::*;

  localparam int PAGE_BYTES   = 32;
  localparam int PAGE_WORDS   = PAGE_BYTES / 8;
  localparam int RANDOM_BEATS = 275;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  // one output beat: a 64-bit word of a written page
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [INDEX_W-1:0] idx;
    logic [WORD_W-1:0]  word;
    logic               fin;
  } page_word_t;

  // one input beat; typed rows carry their own expected page (only word 0 nonzero)
  typedef struct packed {
    logic              act;
    logic              start;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic              typed;
    logic [2:0]        n_words;
    logic [ADDR_W-1:0] base;
    logic [WORD_W-1:0] w0;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready_o;
  logic              action = ACT_DATA;
  logic              chunk_start = 1'b0;
  logic [ADDR_W-1:0] byte_addr = '0;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              out_valid_o;
  logic              out_ready = 1'b0;
  logic [ADDR_W-1:0] page_addr_o;
  logic [INDEX_W-1:0] word_index_o;
  logic [WORD_W-1:0] page_word_o;
  logic              last_word_o;

  // predictor state
  logic [BYTE_W-1:0] pg_bytes [PAGE_BYTES];
  logic [ADDR_W-1:0] pg_base = '0;
  logic [ADDR_W-1:0] pg_next = '0;
  int unsigned       pg_fill = 0;
  bit                pg_dropping = 1'b0;

  page_word_t expected_words [$];
  stim_row_t  dir_rows [$];
  int         mismatches = 0;
  int         live_beats = 0;
  int         stall_left = 0;
  int         cycles = 0;
  bit         quiet = 1'b0;

  always #5 clk = ~clk;

  flash_page_write_combiner_top #(
    .PAGE_BYTES(PAGE_BYTES)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .action_i     (action),
    .chunk_start_i(chunk_start),
    .byte_addr_i  (byte_addr),
    .data_byte_i  (data_byte),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .page_addr_o  (page_addr_o),
    .word_index_o (word_index_o),
    .page_word_o  (page_word_o),
    .last_word_o  (last_word_o)
  );

  // write out the buffered page as little-endian words, then clear it
  function automatic int emit_page(bit keep);
    page_word_t pw;
    for (int k = 0; k < PAGE_WORDS; k++) begin
      pw.addr = pg_base;
      pw.idx  = k[INDEX_W-1:0];
      pw.fin  = (k == PAGE_WORDS - 1);
      pw.word = '0;
      for (int b = 7; b >= 0; b--) pw.word = {pw.word[WORD_W-9:0], pg_bytes[k*8+b]};
      if (keep) expected_words.push_back(pw);
    end
    for (int i = 0; i < PAGE_BYTES; i++) pg_bytes[i] = '0;
    pg_fill = 0;
    return PAGE_WORDS;
  endfunction

  // advance the combiner state by one beat; returns the number of page words it writes
  function automatic int absorb_beat(logic act, logic start, logic [ADDR_W-1:0] addr,
                                     logic [BYTE_W-1:0] data, bit keep);
    int n;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] a;
    n = 0;
    a = addr;
    if (act == ACT_FLUSH) begin
      if (pg_fill > 0) n = emit_page(keep);
      return n;
    end
    if (start) begin
      pg_dropping = 1'b0;
      if (pg_fill == 0) begin
        pg_base = a;
        off = '0;
      end else if (a < pg_base) begin
        pg_dropping = 1'b1;
        return 0;
      end else begin
        off = a - pg_base;
        if (off < pg_fill) begin
          pg_dropping = 1'b1;
          return 0;
        end
        if (off >= PAGE_BYTES) begin
          n = emit_page(keep);
          pg_base = a;
          off = '0;
        end
      end
    end else begin
      if (pg_dropping) return 0;
      a = pg_next;
      if (pg_fill == 0) pg_base = a;
      off = pg_fill;
    end
    pg_bytes[off] = data;
    pg_fill = off + 1;
    pg_next = a + 1;
    if (pg_fill >= PAGE_BYTES) n += emit_page(keep);
    return n;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic void add_row(logic act, logic start, logic [ADDR_W-1:0] addr,
                                  logic [BYTE_W-1:0] data, logic typed, int n_words,
                                  logic [ADDR_W-1:0] base, logic [WORD_W-1:0] w0);
    stim_row_t r;
    r.act = act;
    r.start = start;
    r.addr = addr;
    r.data = data;
    r.typed = typed;
    r.n_words = n_words[2:0];
    r.base = base;
    r.w0 = w0;
    dir_rows.push_back(r);
  endfunction

  // drive one beat, hold it until accepted, then update the prediction
  task automatic send_beat(input stim_row_t row);
    int gap;
    page_word_t pw;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= row.act;
    chunk_start <= row.start;
    byte_addr   <= row.addr;
    data_byte   <= row.data;
    do @(posedge clk); while (!in_ready_o);
    void'(absorb_beat(row.act, row.start, row.addr, row.data, !row.typed));
    if (row.typed) begin
      for (int k = 0; k < row.n_words; k++) begin
        pw.addr = row.base;
        pw.idx  = k[INDEX_W-1:0];
        pw.word = (k == 0) ? row.w0 : '0;
        pw.fin  = (k == PAGE_WORDS - 1);
        expected_words.push_back(pw);
      end
    end
    live_beats++;
  endtask

  // one random chunk, aimed at a spot relative to the current buffer window
  task automatic send_chunk();
    int kind;
    int len;
    logic [ADDR_W-1:0] a;
    stim_row_t row;
    row = '0;
    kind = $urandom_range(0, 99);
    row.addr = $urandom;
    row.data = $urandom;
    if (kind < 8) begin
      row.act = ACT_FLUSH;
      row.start = $urandom_range(0, 1);
      send_beat(row);
      return;
    end
    row.act = ACT_DATA;
    // stray continuation beats with no chunk start
    if (kind < 13) begin
      len = $urandom_range(1, 3);
      for (int k = 0; k < len; k++) begin
        row.addr = $urandom;
        row.data = $urandom;
        send_beat(row);
      end
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2: a = pg_next;
      3: a = (pg_fill > 0) ? pg_base + $urandom_range(pg_fill, PAGE_BYTES - 1) : $urandom;
      4: a = (pg_fill > 0) ? pg_base + $urandom_range(0, pg_fill - 1) : pg_next;
      5: a = pg_base - $urandom_range(1, 64);
      6: a = pg_base + PAGE_BYTES + $urandom_range(0, 40);
      7: a = $urandom;
      8: a = 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: a = pg_base + PAGE_BYTES;
    endcase
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    for (int k = 0; k < len; k++) begin
      row.act   = ACT_DATA;
      row.start = (k == 0);
      row.addr  = (k == 0) ? a : $urandom;
      row.data  = $urandom;
      send_beat(row);
      // now and then a flush breaks the chunk
      if (k > 0 && $urandom_range(0, 39) == 0) begin
        row.act = ACT_FLUSH;
        send_beat(row);
      end
    end
  endtask

  // output side: random stalls, compare each accepted word with the oldest prediction
  always @(posedge clk) begin : out_check
    page_word_t ew;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, page_addr %h index %0d word %h", $time,
                 page_addr_o, word_index_o, page_word_o);
        mismatches++;
      end else begin
        ew = expected_words.pop_front();
        if (page_addr_o !== ew.addr) begin
          $display("%0t: page_addr expected %h got %h", $time, ew.addr, page_addr_o);
          mismatches++;
        end
        if (word_index_o !== ew.idx) begin
          $display("%0t: word_index expected %0d got %0d", $time, ew.idx, word_index_o);
          mismatches++;
        end
        if (page_word_o !== ew.word) begin
          $display("%0t: page_word expected %h got %h", $time, ew.word, page_word_o);
          mismatches++;
        end
        if (last_word_o !== ew.fin) begin
          $display("%0t: last_word expected %b got %b", $time, ew.fin, last_word_o);
          mismatches++;
        end
      end
    end
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      case ($urandom_range(0, 99)) inside
        [0:11]:  stall_left = $urandom_range(1, 3);
        [12:14]: stall_left = $urandom_range(10, 40);
        default: stall_left = 0;
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < PAGE_BYTES; i++) pg_bytes[i] = '0;

    // directed table: typed rows give their page, the others go to the predictor
    add_row(ACT_FLUSH, 1'b0, 32'h0000_0000, 8'h00, 1'b1, 0, '0, '0);  // flush, empty buffer
    add_row(ACT_DATA, 1'b1, 32'hFFFF_FFFE, 8'h11, 1'b1, 0, '0, '0);
    add_row(ACT_DATA, 1'b0, 32'h0000_0000, 8'h22, 1'b1, 0, '0, '0);
    add_row(ACT_DATA, 1'b0, 32'hFFFF_FFFF, 8'h33, 1'b1, 0, '0, '0);   // address wraps
    add_row(ACT_FLUSH, 1'b0, 32'h0000_0000, 8'h00, 1'b1, PAGE_WORDS, 32'hFFFF_FFFE,
            64'h0000_0000_0033_2211);
    add_row(ACT_DATA, 1'b1, 32'h0000_1000, 8'h00, 1'b0, 0, '0, '0);
    add_row(ACT_DATA, 1'b1, 32'h0000_1005, 8'hFF, 1'b0, 0, '0, '0);   // gap inside window
    add_row(ACT_DATA, 1'b0, 32'h0000_0000, 8'h80, 1'b0, 0, '0, '0);
    add_row(ACT_DATA, 1'b1, 32'h0000_1003, 8'h55, 1'b1, 0, '0, '0);   // behind fill
    add_row(ACT_DATA, 1'b0, 32'h0000_0000, 8'h66, 1'b1, 0, '0, '0);
    add_row(ACT_DATA, 1'b1, 32'h0000_0FFF, 8'h77, 1'b1, 0, '0, '0);   // below base
    add_row(ACT_DATA, 1'b0, 32'h0000_0000, 8'h88, 1'b1, 0, '0, '0);
    add_row(ACT_FLUSH, 1'b0, 32'h0000_0000, 8'h00, 1'b1, PAGE_WORDS, 32'h0000_1000,
            64'h0080_FF00_0000_0000);
    add_row(ACT_DATA, 1'b0, 32'h0000_0000, 8'h99, 1'b1, 0, '0, '0);   // still dropping
    add_row(ACT_DATA, 1'b1, 32'h0000_2000, 8'h01, 1'b0, 0, '0, '0);
    add_row(ACT_DATA, 1'b1, 32'h0000_201F, 8'h02, 1'b0, 0, '0, '0);   // last slot fills page
    add_row(ACT_DATA, 1'b1, 32'h0000_3000, 8'h03, 1'b0, 0, '0, '0);
    add_row(ACT_DATA, 1'b1, 32'h0000_3020, 8'h04, 1'b0, 0, '0, '0);   // exactly base + page
    add_row(ACT_DATA, 1'b1, 32'hFFFF_FFFF, 8'hFE, 1'b0, 0, '0, '0);   // far beyond window
    add_row(ACT_DATA, 1'b0, 32'h0000_0000, 8'hEF, 1'b0, 0, '0, '0);
    add_row(ACT_FLUSH, 1'b0, 32'h0000_0000, 8'h00, 1'b0, 0, '0, '0);
    add_row(ACT_DATA, 1'b0, 32'h0000_0000, 8'h5A, 1'b0, 0, '0, '0);   // continuation, empty
    add_row(ACT_FLUSH, 1'b1, 32'hA5A5_5A5A, 8'hC3, 1'b0, 0, '0, '0);  // flush ignores fields
    add_row(ACT_DATA, 1'b1, 32'h0000_0000, 8'hFF, 1'b1, 0, '0, '0);
    add_row(ACT_FLUSH, 1'b0, 32'h0000_0000, 8'h00, 1'b1, PAGE_WORDS, 32'h0000_0000,
            64'h0000_0000_0000_00FF);

    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_beat(dir_rows[i]);

    // random chunks; every third stretch runs with no idling on either side
    live_beats = 0;
    while (live_beats < RANDOM_BEATS) begin
      quiet = ((live_beats / 50) % 3 == 1);
      send_chunk();
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
